FILE: src/coc_pkg.sv
`timescale 1ns / 1ps
// coc_pkg: shared types and default constants for the color occurrence counter.
// No dependencies; used by coc_cell and color_occurrence_counter.

package coc_pkg;

    localparam int COLOR_BITS         = 32;
    localparam int DEF_TABLE_DEPTH    = 64;
    localparam int DEF_COUNT_BITS     = 16;

    // Control flags that ride along with each word through the cell row.
    typedef struct packed {
        logic valid;   // slot carries a word
        logic done;    // a cell already claimed the word (hit or insert)
        logic hit;     // claimed by a matching entry
    } t_tok_ctrl;

endpackage

FILE: src/coc_cell.sv
`timescale 1ns / 1ps
// coc_cell: one table slot (color, count, occupied flag) plus one stage of the word pipe.
// Depends on coc_pkg (t_tok_ctrl).

module coc_cell #(
    parameter int CELL_IDX   = 0,
    parameter int SLOT_BITS  = 6,
    parameter int COUNT_BITS = coc_pkg::DEF_COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  coc_pkg::t_tok_ctrl           i_ctrl,
    input  logic [coc_pkg::COLOR_BITS-1:0] i_color,
    input  logic [SLOT_BITS-1:0]         i_slot,
    input  logic [COUNT_BITS-1:0]        i_count,
    output coc_pkg::t_tok_ctrl           o_ctrl,
    output logic [coc_pkg::COLOR_BITS-1:0] o_color,
    output logic [SLOT_BITS-1:0]         o_slot,
    output logic [COUNT_BITS-1:0]        o_count,
    output logic                         o_used
);

    // Slot state
    logic                           r_used;
    logic [coc_pkg::COLOR_BITS-1:0] r_entry_color;
    logic [COUNT_BITS-1:0]          r_entry_count;

    // Pipe stage
    coc_pkg::t_tok_ctrl             r_ctrl,  n_ctrl;
    logic [coc_pkg::COLOR_BITS-1:0] r_color;
    logic [SLOT_BITS-1:0]           r_slot,  n_slot;
    logic [COUNT_BITS-1:0]          r_count, n_count;

    logic                           open_word;
    logic                           match;
    logic                           fill;
    logic [COUNT_BITS-1:0]          inc_count;

    assign open_word = i_ctrl.valid && !i_ctrl.done;
    assign match     = open_word && r_used && (r_entry_color == i_color);
    assign fill      = open_word && !r_used;
    // saturating increment
    assign inc_count = (&r_entry_count) ? r_entry_count : r_entry_count + COUNT_BITS'(1);

    always_comb begin
        n_ctrl  = i_ctrl;
        n_slot  = i_slot;
        n_count = i_count;
        if (match) begin
            n_ctrl.done = 1'b1;
            n_ctrl.hit  = 1'b1;
            n_slot      = SLOT_BITS'(CELL_IDX);
            n_count     = inc_count;
        end else if (fill) begin
            n_ctrl.done = 1'b1;
            n_ctrl.hit  = 1'b0;
            n_slot      = SLOT_BITS'(CELL_IDX);
            n_count     = COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
            if (fill) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= i_color;
        r_slot  <= n_slot;
        r_count <= n_count;
        if (fill) begin
            r_entry_color <= i_color;
        end
        if (match || fill) begin
            r_entry_count <= n_count;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_color = r_color;
    assign o_slot  = r_slot;
    assign o_count = r_count;
    assign o_used  = r_used;

endmodule

FILE: src/color_occurrence_counter.sv
`timescale 1ns / 1ps
// color_occurrence_counter: top level, a row of TABLE_DEPTH coc_cell slots.
// Depends on coc_pkg and coc_cell.
//
// Usage:
//   Input: drive i_pixel_color and raise i_start; the word is taken at the
//   rising edge where i_start is high and o_busy is low. o_busy is high only
//   while i_rst_n is low, so out of reset a new color may be offered in
//   every cycle.
//   Output: one result word per color, shown for exactly one cycle with
//   o_strobe high: o_was_present, o_slot_index, o_occurrences, o_dropped.
//   Results leave in the order the colors came in. There is no back
//   pressure; the receiver must take each word in its strobe cycle.
// Path: the accepted word is registered in cell 0 and then in each later
//   cell in turn; the strobe comes from the last cell's register.
//   Each word walks the cell row one cell per cycle; cell k owns slot k.
// Throughput: one color per cycle. A word trails its predecessor by at least one
//   cell, so it always sees every update the earlier word made.
// Reset (i_rst_n low, synchronous): all slots become free (fill level 0)
//   and words in flight are discarded. No clearing pass is needed.
// Table full: a new color passes every occupied cell unclaimed and comes
//   out with o_dropped high, slot 0 and count 0; the table is unchanged.

module color_occurrence_counter #(
    parameter int TABLE_DEPTH = coc_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_BITS  = coc_pkg::DEF_COUNT_BITS,
    parameter int SLOT_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [coc_pkg::COLOR_BITS-1:0] i_pixel_color,
    output logic                           o_busy,
    output logic                           o_strobe,
    output logic                           o_was_present,
    output logic [SLOT_BITS-1:0]           o_slot_index,
    output logic [COUNT_BITS-1:0]          o_occurrences,
    output logic                           o_dropped
);

    // Word pipe taps: index k feeds cell k, index TABLE_DEPTH is the row's exit.
    coc_pkg::t_tok_ctrl             ctrl_tap  [TABLE_DEPTH+1];
    logic [coc_pkg::COLOR_BITS-1:0] color_tap [TABLE_DEPTH+1];
    logic [SLOT_BITS-1:0]           slot_tap  [TABLE_DEPTH+1];
    logic [COUNT_BITS-1:0]          count_tap [TABLE_DEPTH+1];

    // Occupied flags; always a run of ones from slot 0 (thermometer fill level).
    logic [TABLE_DEPTH-1:0]         used_vec;

    // no word is taken while reset is held
    assign o_busy = ~i_rst_n;

    // Row entry: a fresh word is open (not yet claimed), slot/count zero.
    always_comb begin
        ctrl_tap[0]       = '0;
        ctrl_tap[0].valid = i_start && !o_busy;
        color_tap[0]      = i_pixel_color;
        slot_tap[0]       = '0;
        count_tap[0]      = '0;
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        coc_cell #(
            .CELL_IDX   (k),
            .SLOT_BITS  (SLOT_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl_tap[k]),
            .i_color (color_tap[k]),
            .i_slot  (slot_tap[k]),
            .i_count (count_tap[k]),
            .o_ctrl  (ctrl_tap[k+1]),
            .o_color (color_tap[k+1]),
            .o_slot  (slot_tap[k+1]),
            .o_count (count_tap[k+1]),
            .o_used  (used_vec[k])
        );
    end

    // Row exit: an unclaimed word found the table full. Slot and count are
    // still the zeros set at entry in that case.
    assign o_strobe      = ctrl_tap[TABLE_DEPTH].valid;
    assign o_was_present = ctrl_tap[TABLE_DEPTH].hit;
    assign o_dropped     = ctrl_tap[TABLE_DEPTH].valid && !ctrl_tap[TABLE_DEPTH].done;
    assign o_slot_index  = slot_tap[TABLE_DEPTH];
    assign o_occurrences = count_tap[TABLE_DEPTH];

    // ---- Assertions ----

    // Slots fill strictly in order from slot 0.
    a_fill_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (used_vec & (used_vec + TABLE_DEPTH'(1))) == '0)
        else $error("occupied slots not contiguous from slot 0");

    // A dropped word carries zero slot and count and is never a hit.
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_dropped) |->
            (!o_was_present && o_slot_index == '0 && o_occurrences == '0))
        else $error("dropped result carries stale fields");

    // A fresh insert reports a count of one.
    a_insert_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_was_present && !o_dropped) |-> (o_occurrences == COUNT_BITS'(1)))
        else $error("insert result count is not one");

    // A hit never reports a zero count (saturation, no wrap).
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_was_present) |-> (o_occurrences != '0 && !o_dropped))
        else $error("hit result wrapped or flagged dropped");

endmodule
